// ===== rtl/positional_insert_list_unit_macros.svh =====
// assertion macros for the positional insert list unit
// expects clk and rst in the scope of each use
`ifndef POSITIONAL_INSERT_LIST_UNIT_MACROS_SVH
`define POSITIONAL_INSERT_LIST_UNIT_MACROS_SVH

// same-cycle implication
`define PIL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional insert list check failed");

// next-cycle implication
`define PIL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional insert list check failed");

`endif

// ===== rtl/pil_pkg.sv =====
// shared types, constants and codes of the positional insert list unit
// no dependencies
package pil_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int TOKEN_W    = 32;
  localparam int POS_W      = 16;
  localparam int PLACE_W    = 6;

  localparam logic [1:0] OP_FRONT = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_POS   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BEYOND  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [TOKEN_W-1:0] token;
    logic signed [POS_W-1:0]   position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      has_entry;
    logic signed [TOKEN_W-1:0] entry_value;
    logic [PLACE_W-1:0]        entry_place;
    logic                      is_last;
  } result_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]         status;
    logic               ins;
    logic [IDX_W-1:0]   place;
    logic [TOKEN_W-1:0] token;
    logic [CNT_W-1:0]   n_new;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/pil_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pil_front.sv =====
// front end: accepts requests, checks them against a shadow count
// depends on pil_pkg
module pil_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  pil_pkg::cmd_t             cmd,
  input  pil_pkg::fifo_stat_t       q_stat,
  output logic                      q_push,
  output pil_pkg::work_t            work,
  output logic [pil_pkg::CNT_W-1:0] shadow_count
);

  localparam int CMP_W = pil_pkg::POS_W + 1;

  logic             list_full;
  logic [CMP_W-1:0] pos_u;
  logic [CMP_W-1:0] limit;

  assign q_push    = push && !q_stat.full;
  assign list_full = (shadow_count == pil_pkg::CNT_W'(pil_pkg::LIST_DEPTH));
  assign pos_u     = {1'b0, cmd.position};
  assign limit     = CMP_W'(shadow_count) + CMP_W'(1);

  always_comb begin
    work.status = pil_pkg::ST_OK;
    work.ins    = 1'b0;
    work.place  = '0;
    work.token  = cmd.token;
    case (cmd.opcode)
      pil_pkg::OP_FRONT: begin
        if (list_full) begin
          work.status = pil_pkg::ST_FULL;
        end else begin
          work.ins = 1'b1;
        end
      end
      pil_pkg::OP_END: begin
        if (list_full) begin
          work.status = pil_pkg::ST_FULL;
        end else begin
          work.ins   = 1'b1;
          work.place = pil_pkg::IDX_W'(shadow_count);
        end
      end
      pil_pkg::OP_POS: begin
        if (cmd.position == '0 || cmd.position[pil_pkg::POS_W-1]) begin
          work.status = pil_pkg::ST_INVALID;
        end else if (pos_u > limit) begin
          work.status = pil_pkg::ST_BEYOND;
        end else if (list_full) begin
          work.status = pil_pkg::ST_FULL;
        end else begin
          work.ins   = 1'b1;
          work.place = pil_pkg::IDX_W'(pos_u - CMP_W'(1));
        end
      end
      default: begin
        work.status = pil_pkg::ST_OK;
      end
    endcase
    work.n_new = shadow_count + pil_pkg::CNT_W'(work.ins);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_count <= '0;
    end else if (q_push) begin
      shadow_count <= work.n_new;
    end
  end

endmodule

// ===== rtl/pil_cmd_queue.sv =====
// two-entry queue of classified requests between front and back
// depends on pil_pkg
module pil_cmd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pil_pkg::work_t      din,
  input  logic                pop,
  output pil_pkg::work_t      dout,
  output pil_pkg::fifo_stat_t stat
);

  pil_pkg::work_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  assign dout       = slots[rd_ptr];
  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/pil_back.sv =====
// back end: applies the insert in place while streaming the list out
// depends on pil_pkg and pil_ram
module pil_back (
  input  logic                clk,
  input  logic                rst,
  input  pil_pkg::fifo_stat_t q_stat,
  input  pil_pkg::work_t      work,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output pil_pkg::result_t    result
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                        state;
  pil_pkg::work_t              cur;
  logic [pil_pkg::IDX_W-1:0]   j;
  logic [pil_pkg::TOKEN_W-1:0] prev;
  logic                        res_valid;

  logic                        adv;
  logic [pil_pkg::CNT_W-1:0]   j_next;
  logic                        last;
  logic [pil_pkg::TOKEN_W-1:0] new_val;
  logic                        re;
  logic [pil_pkg::IDX_W-1:0]   raddr;
  logic                        we;
  logic [pil_pkg::TOKEN_W-1:0] rdata;

  assign empty  = !res_valid;
  assign adv    = !res_valid || pop;
  assign q_pop  = (state == S_IDLE) && !q_stat.empty;
  assign j_next = pil_pkg::CNT_W'(j) + pil_pkg::CNT_W'(1);
  assign last   = (cur.n_new == '0) || (j_next == cur.n_new);

  // old[j] before the insert place, the token at it, old[j-1] after it
  assign new_val = (!cur.ins || j < cur.place) ? rdata :
                   (j == cur.place) ? cur.token : prev;

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (state == S_IDLE) begin
      re = q_pop;
    end else if (adv && !last) begin
      re    = 1'b1;
      raddr = pil_pkg::IDX_W'(j_next);
    end
  end

  assign we = (state == S_RUN) && adv && (cur.n_new != '0) && cur.ins && (j >= cur.place);

  pil_ram #(
    .WIDTH (pil_pkg::TOKEN_W),
    .DEPTH (pil_pkg::LIST_DEPTH)
  ) u_list (
    .clk   (clk),
    .we    (we),
    .waddr (j),
    .wdata (new_val),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_pop) begin
      cur <= work;
      j   <= '0;
    end else if (state == S_RUN && adv) begin
      prev <= rdata;
      result.status <= cur.status;
      result.is_last <= last;
      if (cur.n_new == '0) begin
        result.has_entry   <= 1'b0;
        result.entry_value <= '0;
        result.entry_place <= '0;
      end else begin
        result.has_entry   <= 1'b1;
        result.entry_value <= new_val;
        result.entry_place <= pil_pkg::PLACE_W'(j);
      end
      if (!last) begin
        j <= pil_pkg::IDX_W'(j_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_RUN;
          end
          if (pop) begin
            res_valid <= 1'b0;
          end
        end
        S_RUN: begin
          if (adv) begin
            res_valid <= 1'b1;
            if (last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/positional_insert_list_unit.sv =====
// a request passes the command queue, then the list memory read and the result register of the back
// the back takes the next request only after the last result of the one before, and sets the pace
// walking the list memory through its single read port, one entry per cycle unless pop stalls it
// reset: synchronous, clears the entry count, queue and result valid flag; list memory
// needs no clearing pass since only places below the count are ever used
`include "positional_insert_list_unit_macros.svh"

module positional_insert_list_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  pil_pkg::cmd_t    cmd,
  output logic             empty,
  input  logic             pop,
  output pil_pkg::result_t result
);

  // front to queue
  logic                      q_push;
  pil_pkg::work_t            q_din;
  logic [pil_pkg::CNT_W-1:0] shadow_count;

  // queue to back
  logic                      q_pop;
  pil_pkg::work_t            q_dout;
  pil_pkg::fifo_stat_t       q_stat;

  // the front holds off new requests only while the queue is full
  assign full = q_stat.full;

  // front classifies each request against its own copy of the count,
  // so status is settled before the back ever sees the request
  pil_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .cmd          (cmd),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .work         (q_din),
    .shadow_count (shadow_count)
  );

  // short queue so the front keeps taking requests during a long readout
  pil_cmd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  // back shifts entries in place while emitting the new list in order
  pil_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .work   (q_dout),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  // a result without an entry is the lone result of an empty list
  `PIL_ASSERT_NOW(a_no_entry_alone, !empty && !result.has_entry, result.is_last && result.entry_place == '0)

  // inside a readout the next entry follows at once with the next place
  `PIL_ASSERT_NEXT(a_place_step, pop && !empty && !result.is_last, !empty && result.entry_place == $past(result.entry_place) + pil_pkg::PLACE_W'(1))

  // the shadow count never passes the list depth
  `PIL_ASSERT_NOW(a_count_bound, 1'b1, shadow_count <= pil_pkg::CNT_W'(pil_pkg::LIST_DEPTH))

endmodule

// ===== tb/positional_insert_list_checker.sv =====
// checker for the positional insert list unit: predicts the list readout for every
// accepted request and compares each popped result against it
// depends on pil_pkg for the request and result types and the codes
module positional_insert_list_checker
  import pil_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  cmd_t    cmd,
  input  logic    empty,
  input  logic    pop,
  input  result_t result,
  output int      fail_count,
  output int      expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [TOKEN_W-1:0] list_shadow [LIST_DEPTH];
  int                        shadow_count;
  result_t                   due_results [$];

  // apply one request to the shadow list and queue the readout it causes
  task apply_command(input cmd_t c);
    logic [1:0] st;
    int         slot;
    int         k;
    result_t    r;
    st   = ST_OK;
    slot = -1;
    case (c.opcode)
      OP_FRONT: begin
        if (shadow_count >= LIST_DEPTH) st = ST_FULL;
        else slot = 0;
      end
      OP_END: begin
        if (shadow_count >= LIST_DEPTH) st = ST_FULL;
        else slot = shadow_count;
      end
      OP_POS: begin
        if (c.position <= 0) st = ST_INVALID;
        else if (int'(c.position) > shadow_count + 1) st = ST_BEYOND;
        else if (shadow_count >= LIST_DEPTH) st = ST_FULL;
        else slot = int'(c.position) - 1;
      end
      default: ;
    endcase
    if (slot >= 0) begin
      for (k = shadow_count; k > slot; k--) list_shadow[k] = list_shadow[k-1];
      list_shadow[slot] = c.token;
      shadow_count++;
    end
    if (shadow_count == 0) begin
      r.status      = st;
      r.has_entry   = 1'b0;
      r.entry_value = '0;
      r.entry_place = '0;
      r.is_last     = 1'b1;
      due_results.push_back(r);
    end else begin
      for (k = 0; k < shadow_count; k++) begin
        r.status      = st;
        r.has_entry   = 1'b1;
        r.entry_value = list_shadow[k];
        r.entry_place = PLACE_W'(k);
        r.is_last     = (k == shadow_count - 1);
        due_results.push_back(r);
      end
    end
  endtask

  task check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      $error("result popped with none expected");
      fail_count++;
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
      if (got.has_entry !== want.has_entry) begin
        $error("has_entry: expected %0d, actual %0d", want.has_entry, got.has_entry);
        fail_count++;
      end
      if (got.entry_value !== want.entry_value) begin
        $error("entry_value: expected %0d, actual %0d", want.entry_value, got.entry_value);
        fail_count++;
      end
      if (got.entry_place !== want.entry_place) begin
        $error("entry_place: expected %0d, actual %0d", want.entry_place, got.entry_place);
        fail_count++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last: expected %0d, actual %0d", want.is_last, got.is_last);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count    = 0;
    expected_left = 0;
    shadow_count  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      due_results.delete();
    end else begin
      if (pop && !empty) check_result(result);
      if (push && !full) apply_command(cmd);
    end
    expected_left = due_results.size();
  end

endmodule

// ===== tb/tb_positional_insert_list_unit.sv =====
// top of the positional insert list unit testbench: clock, reset, request stimulus
// with random idling on both sides, and the verdict
// depends on pil_pkg, the unit under test and positional_insert_list_checker
module tb_positional_insert_list_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pil_pkg::*;

  localparam int RANDOM_ITEMS = 330;
  localparam int CALM_ITEMS   = 40;      // tail of the run with no idling
  localparam int LIMIT_CYCLES = 4000000;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  cmd_t    cmd;
  logic    empty;
  logic    pop;
  result_t result;

  int fail_count;
  int expected_left;
  int cycle_count;
  int fill_level;    // rough count of held tokens, only to steer positions
  int send_calm;     // requests left in a stretch without gaps
  bit calm_tail;     // no idling on either side any more

  positional_insert_list_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .cmd    (cmd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  positional_insert_list_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit as a guard against a hung handshake
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_positional_insert_list_unit: errors");
    $finish;
  end

  // result side: pop held high, dropped in bursts of random length
  initial begin
    int hold;
    int free_run;
    hold     = 0;
    free_run = 0;
    pop      = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_tail || rst) begin
        pop <= !rst;
      end else if (hold > 0) begin
        pop  <= 1'b0;
        hold--;
      end else if (free_run > 0) begin
        pop <= 1'b1;
        free_run--;
      end else if ($urandom_range(0, 99) < 8) begin
        // burst of stall, this cycle included
        pop  <= 1'b0;
        hold = $urandom_range(1, 13) - 1;
      end else if ($urandom_range(0, 99) < 3) begin
        pop      <= 1'b1;
        free_run = $urandom_range(30, 300);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // one request: present it at the falling edge, hold until taken, then maybe a gap
  task send_cmd(input logic [1:0] op, input logic [31:0] tok, input logic signed [15:0] pos);
    cmd_t c;
    int   gap;
    c.opcode   = op;
    c.token    = tok;
    c.position = pos;
    push <= 1'b1;
    cmd  <= c;
    do @(posedge clk); while (full);
    @(negedge clk);
    // keep the steering count in step with what the list should hold
    if (fill_level < LIST_DEPTH) begin
      if (op == OP_FRONT || op == OP_END) fill_level++;
      else if (op == OP_POS && pos >= 1 && int'(pos) <= fill_level + 1) fill_level++;
    end
    if (calm_tail) begin
      gap = 0;
    end else if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(0, 99) < 5) begin
      send_calm = $urandom_range(5, 30);
      gap       = 0;
    end else if ($urandom_range(0, 99) < 35) begin
      gap = $urandom_range(1, 13);
    end else begin
      gap = 0;
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // random request, mostly inserts with sensible positions, some bad positions
  task send_random();
    logic [1:0]         op;
    logic signed [15:0] pos;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) op = OP_FRONT;
    else if (pick < 44) op = OP_END;
    else if (pick < 84) op = OP_POS;
    else op = OP_READ;
    pos = 16'($urandom);
    if (op == OP_POS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3, 4: pos = 16'($urandom_range(1, fill_level + 1));
        5: pos = 16'(fill_level + 1);                           // append by position
        6: pos = 16'(fill_level + 1 + $urandom_range(1, 3));    // just past the end
        7: pos = 16'($urandom) | 16'h8000;                      // negative
        8: pos = '0;
        default: ;                                              // anything at all
      endcase
    end
    send_cmd(op, $urandom, pos);
  endtask

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    cmd        = '0;
    fill_level = 0;
    send_calm  = 0;
    calm_tail  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list readout and bad positions on an empty list
    send_cmd(OP_READ, 32'h1234_5678, 16'sd0);
    send_cmd(OP_POS, 32'h0bad_0001, 16'sd0);           // invalid, zero
    send_cmd(OP_POS, 32'h0bad_0002, -16'sd32768);      // invalid, most negative
    send_cmd(OP_POS, 32'h0bad_0003, -16'sd1);          // invalid, minus one
    send_cmd(OP_POS, 32'h0bad_0004, 16'sd2);           // beyond on an empty list
    send_cmd(OP_POS, 32'h0bad_0005, 16'sd32767);       // beyond, largest position
    // position one into an empty list acts like insert at front
    send_cmd(OP_POS, 32'h7fff_ffff, 16'sd1);
    send_cmd(OP_FRONT, 32'h8000_0000, 16'sd32767);     // position ignored
    send_cmd(OP_END, 32'h0000_0000, -16'sd32768);
    send_cmd(OP_END, 32'hffff_ffff, 16'sd0);
    send_cmd(OP_POS, 32'h5555_5555, 16'sd5);           // count plus one
    send_cmd(OP_POS, 32'h0bad_0006, 16'sd7);           // count plus two
    send_cmd(OP_POS, 32'haaaa_aaaa, 16'sd1);           // position one on a non-empty list
    send_cmd(OP_POS, 32'h0000_0001, 16'sd3);           // middle
    send_cmd(OP_READ, 32'hffff_ffff, 16'sd2);          // read ignores token and position
    send_cmd(OP_POS, 32'h0bad_0007, 16'sh7fff);
    send_cmd(OP_FRONT, 32'h0000_0002, 16'sh8000);

    // random part; the list only grows, so it fills and the tail sees the full case
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
      send_random();
    end
    // on a full list: position count plus one is full, count plus two is beyond
    send_cmd(OP_POS, 32'h0bad_0008, 16'(LIST_DEPTH + 1));
    send_cmd(OP_POS, 32'h0bad_0009, 16'(LIST_DEPTH + 2));
    send_cmd(OP_POS, 32'h0bad_000a, -16'sd5);
    push <= 1'b0;

    // drain, then give stray results time to show
    while (expected_left != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);

    if (fail_count == 0 && expected_left == 0) begin
      $display("tb_positional_insert_list_unit: clean");
    end else begin
      $display("tb_positional_insert_list_unit: errors");
    end
    $finish;
  end

endmodule
